// ----- design/ece_pkg.sv -----
// Shared types, constants and arithmetic helpers of the easing curve evaluator.
`timescale 1ns / 1ps

package ece_pkg;

  localparam int MODE_WIDTH = 4;
  localparam int CFG_INDEX_WIDTH = 4;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_CIRC_INOUT = 4'd0,
    MODE_CIRC_IN    = 4'd1,
    MODE_CIRC_OUT   = 4'd2,
    MODE_QUAD_INOUT = 4'd3,
    MODE_QUINT_IN   = 4'd4,
    MODE_QUINT_OUT  = 4'd5,
    MODE_LINEAR     = 4'd6,
    MODE_SINE_INOUT = 4'd7,
    MODE_SINE_OUT   = 4'd8,
    MODE_SINE_IN    = 4'd9
  } curve_mode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CURVE_MODE    = 4'd0,
    REG_START_VALUE   = 4'd1,
    REG_CHANGE_AMOUNT = 4'd2,
    REG_TOTAL_TICKS   = 4'd3
  } cfg_reg_t;

  // Normalized time and curve values are unsigned Q1.16 in [0, 1.0].
  localparam int FRAC_BITS = 16;
  typedef logic [FRAC_BITS:0] q16_t;
  localparam q16_t ONE_Q16  = 17'h1_0000;
  localparam q16_t HALF_Q16 = 17'h0_8000;
  localparam int ROUND_HALF = 32768;

  // Square root of a 34-bit radicand gives 17 result bits.
  localparam int SQRT_DIGITS = 17;
  localparam logic [33:0] SQ_FULL = 34'h1_0000_0000;

  // CORDIC runs in Q2.30 with a 33-bit signed datapath.
  localparam int CORDIC_STEPS = 20;
  typedef logic signed [32:0] cordic_t;
  localparam cordic_t CORDIC_X0 = 33'sd652032874;
  localparam cordic_t ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
    33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
    33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
    33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304
  };

  // Q1.16 product rounded to nearest.
  function automatic q16_t qmul(input q16_t a, input q16_t b);
    logic [33:0] p;
    p = a * b + 34'(ROUND_HALF);
    return p[32:16];
  endfunction

  // Clamp a Q2.30 CORDIC output to [0, 1.0] and round it to Q1.16.
  function automatic q16_t to_q16(input cordic_t v);
    logic [31:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > 33'sd1073741824) begin
      c = 32'h4000_0000;
    end else begin
      c = v[31:0];
    end
    c = c + 32'd8192;
    return c[30:14];
  endfunction

endpackage

// ----- design/ece_if.sv -----
// Handshake channels of the easing curve evaluator: elapsed ticks in, eased value out.
`timescale 1ns / 1ps

interface ece_tick_if #(
  parameter int TIME_WIDTH = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] elapsed_ticks;

  modport source (output valid, output elapsed_ticks, input ready);
  modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface ece_value_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink (input valid, input eased_value, output ready);
endinterface

// ----- design/easing_curve_evaluator_core.sv -----
// Top level of the easing curve evaluator: a fully pipelined curve and scaling datapath.
`timescale 1ns / 1ps

// Channel    Role    Payload                          Width
// tick_ch    sink    elapsed_ticks, unsigned          TIME_WIDTH
// value_ch   source  eased_value, signed Q16.16       VALUE_WIDTH
// cfg        write   cfg_we, cfg_index, cfg_data      4 / max(VALUE_WIDTH, TIME_WIDTH)
//
// One item enters per cycle unless a stall holds the first stage.
// The depth comes from the 16-step time divider and the 20-step CORDIC, one step per stage.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
// A stall stops only the stages behind an occupied one, so bubbles are squeezed out and
// input items still enter while a finished result waits at the output and a stage is free.

module easing_curve_evaluator_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ece_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [((VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH)-1:0] cfg_data,
  ece_tick_if.sink                              tick_ch,
  ece_value_if.source                           value_ch
);
  import ece_pkg::*;

  // Stage map. Stage 0 registers the input, the divider works one quotient bit per
  // stage, then the curve units run side by side and merge into one curve value.
  localparam int S_IN    = 0;
  localparam int S_DIV0  = S_IN + 1;
  localparam int S_T     = S_DIV0 + FRAC_BITS;
  localparam int S_ARG   = S_T + 1;
  localparam int S_U0    = S_ARG + 1;
  localparam int S_SQ0   = S_U0 + 1;
  localparam int S_QUINT = S_U0 + 4;
  localparam int S_SQRT  = S_SQ0 + SQRT_DIGITS;
  localparam int S_SINE  = S_U0 + CORDIC_STEPS;
  localparam int S_MUL   = S_SINE + 1;
  localparam int S_OUT   = S_MUL + 1;

  localparam int PROD_WIDTH = VALUE_WIDTH + FRAC_BITS + 1;
  localparam int SUM_WIDTH  = VALUE_WIDTH + 2;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {3'b000, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {3'b111, {(VALUE_WIDTH-1){1'b0}}};

  // Configuration registers. The user must change them only while the pipeline is empty;
  // the block does not enforce it, and every stage reads them directly.
  curve_mode_t                   curve_mode;
  logic signed [VALUE_WIDTH-1:0] start_value;
  logic signed [VALUE_WIDTH-1:0] change_amount;
  logic [TIME_WIDTH-1:0]         total_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode    <= MODE_LINEAR;
      start_value   <= '0;
      change_amount <= '0;
      total_ticks   <= TIME_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURVE_MODE:    curve_mode    <= curve_mode_t'(cfg_data[MODE_WIDTH-1:0]);
        REG_START_VALUE:   start_value   <= cfg_data[VALUE_WIDTH-1:0];
        REG_CHANGE_AMOUNT: change_amount <= cfg_data[VALUE_WIDTH-1:0];
        REG_TOTAL_TICKS:   total_ticks   <= cfg_data[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage enables. A stage may load when it is empty or when the
  // stage after it loads in the same cycle.
  logic [S_OUT:0] v;
  logic [S_OUT:0] en;

  always_comb begin
    en[S_OUT] = !v[S_OUT] || value_ch.ready;
    for (int k = S_OUT - 1; k >= S_IN; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[S_IN]) begin
        v[S_IN] <= tick_ch.valid;
      end
      for (int k = S_IN + 1; k <= S_OUT; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign tick_ch.ready = en[S_IN];

  // Time divider: restoring division of elapsed/total, one quotient bit per stage.
  // An elapsed count at or past the total (a total of zero included) pins t at 1.0.
  logic [TIME_WIDTH-1:0] d_rem [S_IN:S_T-1];
  logic [FRAC_BITS-1:0]  d_quo [S_IN:S_T-1];
  logic                  d_sat [S_IN:S_T-1];
  logic [TIME_WIDTH:0]   div_shift [S_DIV0:S_T-1];
  logic [TIME_WIDTH:0]   div_diff  [S_DIV0:S_T-1];
  logic                  div_bit   [S_DIV0:S_T-1];

  always_comb begin
    for (int k = S_DIV0; k < S_T; k++) begin
      div_shift[k] = {d_rem[k-1], 1'b0};
      div_diff[k]  = div_shift[k] - {1'b0, total_ticks};
      div_bit[k]   = div_shift[k] >= {1'b0, total_ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      d_sat[S_IN] <= tick_ch.elapsed_ticks[TIME_WIDTH-1:0] >= total_ticks;
      d_rem[S_IN] <= tick_ch.elapsed_ticks[TIME_WIDTH-1:0];
      d_quo[S_IN] <= '0;
    end
    for (int k = S_DIV0; k < S_T; k++) begin
      if (en[k]) begin
        d_sat[k] <= d_sat[k-1];
        d_rem[k] <= div_bit[k] ? div_diff[k][TIME_WIDTH-1:0] : div_shift[k][TIME_WIDTH-1:0];
        d_quo[k] <= {d_quo[k-1][FRAC_BITS-2:0], div_bit[k]};
      end
    end
  end

  // Normalized time t in Q1.16.
  q16_t t_q;

  always_ff @(posedge clk) begin
    if (en[S_T]) begin
      t_q <= d_sat[S_T-1] ? ONE_Q16 : {1'b0, d_quo[S_T-1]};
    end
  end

  // Argument stage: pick the operand of each curve unit from t, s = 1 - t and the half.
  q16_t    arg_s;
  logic    arg_lo;
  q16_t    arg_sqx;
  cordic_t arg_z;

  always_comb begin
    arg_s  = ONE_Q16 - t_q;
    arg_lo = t_q < HALF_Q16;
    unique case (curve_mode)
      MODE_CIRC_INOUT: begin
        arg_sqx = arg_lo ? {t_q[FRAC_BITS-1:0], 1'b0} : {arg_s[FRAC_BITS-1:0], 1'b0};
      end
      MODE_CIRC_OUT: arg_sqx = arg_s;
      default:       arg_sqx = t_q;
    endcase
    if (curve_mode == MODE_SINE_INOUT) begin
      arg_z = arg_lo ? {1'b0, t_q, {(FRAC_BITS-1){1'b0}}}
                     : {1'b0, arg_s, {(FRAC_BITS-1){1'b0}}};
    end else begin
      arg_z = {2'b00, t_q, {(FRAC_BITS-2){1'b0}}};
    end
  end

  q16_t a_t;
  q16_t a_sqx;
  q16_t a_qx;
  q16_t a_dx;
  logic lo_q [S_ARG:S_SINE-1];

  // CORDIC registers; the argument stage seeds them with the start vector.
  cordic_t cx_q [S_ARG:S_SINE-1];
  cordic_t cy_q [S_ARG:S_SINE-1];
  cordic_t cz_q [S_ARG:S_SINE-1];

  // CORDIC rotation steps, one per stage.
  cordic_t cx_n [S_U0:S_SINE-1];
  cordic_t cy_n [S_U0:S_SINE-1];
  cordic_t cz_n [S_U0:S_SINE-1];

  always_comb begin
    for (int k = S_U0; k < S_SINE; k++) begin
      if (cz_q[k-1][32]) begin
        cx_n[k] = cx_q[k-1] + (cy_q[k-1] >>> (k - S_U0));
        cy_n[k] = cy_q[k-1] - (cx_q[k-1] >>> (k - S_U0));
        cz_n[k] = cz_q[k-1] + ATAN_TAB[k - S_U0];
      end else begin
        cx_n[k] = cx_q[k-1] - (cy_q[k-1] >>> (k - S_U0));
        cy_n[k] = cy_q[k-1] + (cx_q[k-1] >>> (k - S_U0));
        cz_n[k] = cz_q[k-1] - ATAN_TAB[k - S_U0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_ARG]) begin
      a_t         <= t_q;
      a_sqx       <= arg_sqx;
      a_qx        <= (curve_mode == MODE_QUINT_IN) ? t_q : arg_s;
      a_dx        <= arg_lo ? t_q : arg_s;
      lo_q[S_ARG] <= arg_lo;
      cx_q[S_ARG] <= CORDIC_X0;
      cy_q[S_ARG] <= '0;
      cz_q[S_ARG] <= arg_z;
    end
    for (int k = S_U0; k < S_SINE; k++) begin
      if (en[k]) begin
        lo_q[k] <= lo_q[k-1];
      end
    end

    // CORDIC steps.
    for (int k = S_U0; k < S_SINE; k++) begin
      if (en[k]) begin
        cx_q[k] <= cx_n[k];
        cy_q[k] <= cy_n[k];
        cz_q[k] <= cz_n[k];
      end
    end
  end

  // First unit stage: quadratic curve, the first quintic product and the radicand.
  logic [33:0] quad_sq;
  logic [33:0] quad_rnd;
  q16_t        quad_v;
  logic [33:0] sq_prod;

  always_comb begin
    quad_sq  = a_dx * a_dx;
    quad_rnd = {quad_sq[32:0], 1'b0} + 34'(ROUND_HALF);
    quad_v   = quad_rnd[32:16];
    sq_prod  = a_sqx * a_sqx;
  end

  q16_t        f_q    [S_U0:S_SINE];
  q16_t        qx_q   [S_U0:S_QUINT-1];
  q16_t        qp_q   [S_U0:S_QUINT-1];
  logic [33:0] sqn_q  [S_U0:S_SQRT-1];
  logic [18:0] srem_q [S_U0:S_SQRT-1];
  q16_t        sroot_q [S_U0:S_SQRT-1];

  // Square root digit recurrence, one result bit per stage.
  logic [20:0] sq_rr    [S_SQ0:S_SQRT-1];
  logic [20:0] sq_trial [S_SQ0:S_SQRT-1];
  logic [20:0] sq_diff  [S_SQ0:S_SQRT-1];
  logic        sq_ge    [S_SQ0:S_SQRT-1];

  always_comb begin
    for (int k = S_SQ0; k < S_SQRT; k++) begin
      sq_rr[k]    = {srem_q[k-1], sqn_q[k-1][33:32]};
      sq_trial[k] = {2'b00, sroot_q[k-1], 2'b01};
      sq_diff[k]  = sq_rr[k] - sq_trial[k];
      sq_ge[k]    = sq_rr[k] >= sq_trial[k];
    end
  end

  // Curve values that the longer units hand over to the running curve value.
  q16_t                f_quint;
  q16_t                f_sqrt;
  q16_t                f_sine;
  q16_t                sq_root;
  q16_t                sin_v;
  q16_t                cos_v;
  logic [FRAC_BITS+1:0] sq_sum_lo;
  logic [FRAC_BITS+1:0] sq_sum_hi;
  logic [FRAC_BITS+1:0] cs_sum_lo;
  logic [FRAC_BITS+1:0] cs_sum_hi;

  always_comb begin
    unique case (curve_mode)
      MODE_QUINT_IN:  f_quint = qp_q[S_QUINT-1];
      MODE_QUINT_OUT: f_quint = ONE_Q16 - qp_q[S_QUINT-1];
      default:        f_quint = f_q[S_QUINT-1];
    endcase

    sq_root   = sroot_q[S_SQRT-1];
    sq_sum_lo = {1'b0, ONE_Q16} - {1'b0, sq_root} + 18'd1;
    sq_sum_hi = {1'b0, ONE_Q16} + {1'b0, sq_root} + 18'd1;
    unique case (curve_mode)
      MODE_CIRC_INOUT: f_sqrt = lo_q[S_SQRT-1] ? sq_sum_lo[FRAC_BITS+1:1]
                                               : sq_sum_hi[FRAC_BITS+1:1];
      MODE_CIRC_IN:    f_sqrt = ONE_Q16 - sq_root;
      MODE_CIRC_OUT:   f_sqrt = sq_root;
      default:         f_sqrt = f_q[S_SQRT-1];
    endcase

    sin_v     = to_q16(cy_q[S_SINE-1]);
    cos_v     = to_q16(cx_q[S_SINE-1]);
    cs_sum_lo = {1'b0, ONE_Q16} - {1'b0, cos_v} + 18'd1;
    cs_sum_hi = {1'b0, ONE_Q16} + {1'b0, cos_v} + 18'd1;
    unique case (curve_mode)
      MODE_SINE_INOUT: f_sine = lo_q[S_SINE-1] ? cs_sum_lo[FRAC_BITS+1:1]
                                               : cs_sum_hi[FRAC_BITS+1:1];
      MODE_SINE_OUT:   f_sine = sin_v;
      MODE_SINE_IN:    f_sine = ONE_Q16 - cos_v;
      default:         f_sine = f_q[S_SINE-1];
    endcase
  end

  always_ff @(posedge clk) begin
    // First unit stage.
    if (en[S_U0]) begin
      if (curve_mode == MODE_QUAD_INOUT) begin
        f_q[S_U0] <= lo_q[S_ARG] ? quad_v : ONE_Q16 - quad_v;
      end else begin
        f_q[S_U0] <= a_t;
      end
      qx_q[S_U0]    <= a_qx;
      qp_q[S_U0]    <= qmul(a_qx, a_qx);
      sqn_q[S_U0]   <= SQ_FULL - sq_prod;
      srem_q[S_U0]  <= '0;
      sroot_q[S_U0] <= '0;
    end

    // Quintic power: one rounded product per stage.
    for (int k = S_U0 + 1; k < S_QUINT; k++) begin
      if (en[k]) begin
        qx_q[k] <= qx_q[k-1];
        qp_q[k] <= qmul(qp_q[k-1], qx_q[k-1]);
      end
    end

    // Square root digits.
    for (int k = S_SQ0; k < S_SQRT; k++) begin
      if (en[k]) begin
        sqn_q[k]   <= {sqn_q[k-1][31:0], 2'b00};
        srem_q[k]  <= sq_ge[k] ? sq_diff[k][18:0] : sq_rr[k][18:0];
        sroot_q[k] <= {sroot_q[k-1][FRAC_BITS-1:0], sq_ge[k]};
      end
    end

    // Running curve value; each unit overwrites it at the stage where it finishes.
    for (int k = S_U0 + 1; k <= S_SINE; k++) begin
      if (en[k]) begin
        if (k == S_QUINT) begin
          f_q[k] <= f_quint;
        end else if (k == S_SQRT) begin
          f_q[k] <= f_sqrt;
        end else if (k == S_SINE) begin
          f_q[k] <= f_sine;
        end else begin
          f_q[k] <= f_q[k-1];
        end
      end
    end
  end

  // Scaling: |change| * f, rounded half away from zero, then added to start with
  // the sign of change and saturated to the value range.
  logic [VALUE_WIDTH-1:0]       chg_mag;
  logic [PROD_WIDTH-1:0]        prod_q;
  logic [PROD_WIDTH-1:0]        prod_rnd;
  logic [VALUE_WIDTH:0]         scaled;
  logic signed [SUM_WIDTH-1:0]  start_ext;
  logic signed [SUM_WIDTH-1:0]  scaled_ext;
  logic signed [SUM_WIDTH-1:0]  sum;
  logic [VALUE_WIDTH-1:0]       sum_sat;
  logic [VALUE_WIDTH-1:0]       out_value;

  always_comb begin
    chg_mag    = change_amount[VALUE_WIDTH-1] ? $unsigned(-change_amount)
                                              : $unsigned(change_amount);
    prod_rnd   = prod_q + PROD_WIDTH'(ROUND_HALF);
    scaled     = prod_rnd[PROD_WIDTH-1:FRAC_BITS];
    start_ext  = $signed({{2{start_value[VALUE_WIDTH-1]}}, start_value});
    scaled_ext = $signed({1'b0, scaled});
    sum        = change_amount[VALUE_WIDTH-1] ? start_ext - scaled_ext
                                              : start_ext + scaled_ext;
    priority if (sum > SUM_MAX) begin
      sum_sat = SUM_MAX[VALUE_WIDTH-1:0];
    end else if (sum < SUM_MIN) begin
      sum_sat = SUM_MIN[VALUE_WIDTH-1:0];
    end else begin
      sum_sat = sum[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      prod_q <= chg_mag * f_q[S_SINE];
    end
    if (en[S_OUT]) begin
      out_value <= sum_sat;
    end
  end

  assign value_ch.valid       = v[S_OUT];
  assign value_ch.eased_value = out_value;

  // Input is refused only when the first stage is full and cannot move on.
  assert property (@(posedge clk) disable iff (rst)
    !en[S_IN] |-> (v[S_IN] && !en[S_IN+1]))
    else $error("input refused while the first stage could move");

  // A full stage that is held keeps its item.
  assert property (@(posedge clk) disable iff (rst)
    (v[S_MUL] && !en[S_MUL]) |=> v[S_MUL])
    else $error("held item lost in the scaling stage");

  // Normalized time never exceeds 1.0.
  assert property (@(posedge clk) disable iff (rst)
    v[S_ARG] |-> (a_t <= ONE_Q16))
    else $error("normalized time above one");

  // The merged curve value stays within [0, 1.0].
  assert property (@(posedge clk) disable iff (rst)
    v[S_SINE] |-> (f_q[S_SINE] <= ONE_Q16))
    else $error("curve value above one");

endmodule
